// ----- hdl/bci_pkg.sv -----
package bci_pkg;

  localparam int BP_REGS     = 8;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int MV_W        = 16;
  localparam int FRAC_W      = 17;
  localparam int Q_W         = 16;
  // (N-1)*w fits in 19 bits for N up to 8
  localparam int ACC_W       = 19;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [FRAC_W-1:0] FULL_SCALE = 17'h10000;

  typedef logic [MV_W-1:0] mv_t;
  typedef logic [BP_REGS-1:0][MV_W-1:0] bp_tbl_t;

  localparam bp_tbl_t BP_RESET = {
    16'd42000, 16'd40000, 16'd38500, 16'd37000,
    16'd35500, 16'd34000, 16'd32000, 16'd30000
  };

  typedef enum logic [1:0] {
    SEG_ZERO,
    SEG_FULL,
    SEG_INTERP
  } seg_kind_t;

  typedef struct packed {
    seg_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    mv_t               lo;
    mv_t               hi;
    mv_t               volt;
  } seg_t;

endpackage

// ----- hdl/bci_front.sv -----
module bci_front #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bci_pkg::mv_t     in_voltage_mv,
  input  bci_pkg::bp_tbl_t bp,
  input  logic             q_full,
  output logic             q_push,
  output bci_pkg::seg_t    q_push_data
);

  localparam int NB = (NUM_BREAKPOINTS < 2) ? 2 :
                      (NUM_BREAKPOINTS > bci_pkg::BP_REGS) ? bci_pkg::BP_REGS :
                      NUM_BREAKPOINTS;

  logic          vld_r;
  logic          vld_nxt;
  bci_pkg::seg_t seg_r;
  bci_pkg::seg_t seg_nxt;
  logic          load;
  logic          found;

  assign in_stall    = vld_r && q_full;
  assign q_push      = vld_r && !q_full;
  assign q_push_data = seg_r;
  assign load        = in_valid && !in_stall;

  // first breakpoint strictly above the sample closes the segment
  always_comb begin
    found        = 1'b0;
    seg_nxt.idx  = bci_pkg::IDX_W'(1);
    seg_nxt.lo   = bp[0];
    seg_nxt.hi   = bp[1];
    seg_nxt.volt = in_voltage_mv;
    for (int i = 1; i < bci_pkg::BP_REGS; i++) begin
      if (i < NB && !found && in_voltage_mv < bp[i]) begin
        found       = 1'b1;
        seg_nxt.idx = bci_pkg::IDX_W'(i);
        seg_nxt.lo  = bp[i-1];
        seg_nxt.hi  = bp[i];
      end
    end
    if (in_voltage_mv < bp[0]) begin
      seg_nxt.kind = bci_pkg::SEG_ZERO;
    end else if (!found) begin
      seg_nxt.kind = bci_pkg::SEG_FULL;
    end else begin
      seg_nxt.kind = bci_pkg::SEG_INTERP;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

// ----- hdl/bci_queue.sv -----
module bci_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bci_pkg::seg_t push_data,
  output logic          full,
  input  logic          pop,
  output bci_pkg::seg_t pop_data,
  output logic          empty
);

  bci_pkg::seg_t                   mem [bci_pkg::QUEUE_DEPTH];
  logic [bci_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [bci_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [bci_pkg::QCNT_W-1:0]      cnt_r;
  logic [bci_pkg::QCNT_W-1:0]      cnt_nxt;

  assign full     = (cnt_r == bci_pkg::QCNT_W'(bci_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + bci_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bci_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/bci_back.sv -----
module bci_back #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  bci_pkg::seg_t                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bci_pkg::FRAC_W-1:0]    out_charge_fraction
);

  localparam int NB = (NUM_BREAKPOINTS < 2) ? 2 :
                      (NUM_BREAKPOINTS > bci_pkg::BP_REGS) ? bci_pkg::BP_REGS :
                      NUM_BREAKPOINTS;
  localparam int NM1   = NB - 1;
  localparam int CNT_W = $clog2(bci_pkg::Q_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                        state_r;
  bci_pkg::seg_t                 seg_r;
  logic [bci_pkg::ACC_W-1:0]     acc_r;
  logic [bci_pkg::ACC_W-1:0]     den_r;
  logic [bci_pkg::Q_W-1:0]       q_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          out_valid_r;
  logic [bci_pkg::FRAC_W-1:0]    res_r;

  bci_pkg::mv_t                  width;
  logic [bci_pkg::ACC_W-1:0]     acc_init;
  logic [bci_pkg::ACC_W-1:0]     den_init;
  logic [bci_pkg::ACC_W:0]       trial;
  logic [bci_pkg::ACC_W:0]       diff;
  logic                          ge;

  assign q_pop               = (state_r == ST_IDLE) && !q_empty;
  assign out_valid           = out_valid_r;
  assign out_charge_fraction = res_r;

  // numerator is acc_init * 2^16; acc_init < den_init so the quotient fits 16 bits
  assign width    = seg_r.hi - seg_r.lo;
  assign acc_init = bci_pkg::ACC_W'(seg_r.idx - bci_pkg::IDX_W'(1))
                    * bci_pkg::ACC_W'(width)
                    + bci_pkg::ACC_W'(seg_r.volt - seg_r.lo);
  assign den_init = bci_pkg::ACC_W'(NM1) * bci_pkg::ACC_W'(width);

  assign trial = {acc_r, 1'b0};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            seg_r <= q_data;
            unique case (q_data.kind)
              bci_pkg::SEG_ZERO: begin
                res_r       <= '0;
                out_valid_r <= 1'b1;
                state_r     <= ST_OUT;
              end
              bci_pkg::SEG_FULL: begin
                res_r       <= bci_pkg::FULL_SCALE;
                out_valid_r <= 1'b1;
                state_r     <= ST_OUT;
              end
              default: begin
                state_r <= ST_PREP;
              end
            endcase
          end
        end
        ST_PREP: begin
          acc_r   <= acc_init;
          den_r   <= den_init;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (ge) begin
            acc_r <= diff[bci_pkg::ACC_W-1:0];
          end else begin
            acc_r <= trial[bci_pkg::ACC_W-1:0];
          end
          q_r   <= {q_r[bci_pkg::Q_W-2:0], ge};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(bci_pkg::Q_W - 1)) begin
            res_r       <= {1'b0, q_r[bci_pkg::Q_W-2:0], ge};
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (acc_r < den_r))
    else $error("partial remainder not below divisor");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (den_r != '0))
    else $error("zero-width segment reached the divider");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r <= bci_pkg::FULL_SCALE))
    else $error("charge fraction above full scale");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE))
    else $error("popped transaction dropped");

endmodule

// ----- hdl/battery_charge_interpolator.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------
// in       | in_valid / in_stall | in_voltage_mv[15:0]
// out      | out_valid/out_stall | out_charge_fraction[16:0]
// cfg      | cfg_wr_en           | cfg_index[3:0], cfg_data[15:0]
//
// Interpolated samples go from the front register into the queue, are popped by the
// back end, get their operands set up in ST_PREP and then pass the restoring divider,
// which forms a 16-bit quotient; the back end takes a new sample only once the last one
// has left ST_OUT. Out-of-range samples skip set-up and divider and go straight to ST_OUT.
// Synchronous active-low reset restores the breakpoint table and empties all stages.
// The front keeps accepting while the back divides or waits on out_stall,
// until the two-entry queue and front register are full.
module battery_charge_interpolator #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bci_pkg::MV_W-1:0]        in_voltage_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bci_pkg::FRAC_W-1:0]      out_charge_fraction,
  input  logic                            cfg_wr_en,
  input  logic [bci_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bci_pkg::MV_W-1:0]        cfg_data
);

  bci_pkg::bp_tbl_t bp_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  bci_pkg::seg_t    q_push_data;
  bci_pkg::seg_t    q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= bci_pkg::BP_RESET;
    end else if (cfg_wr_en && cfg_index < bci_pkg::CFG_IDX_W'(bci_pkg::BP_REGS)) begin
      bp_r[cfg_index[bci_pkg::IDX_W-1:0]] <= cfg_data;
    end
  end

  bci_front #(
    .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_voltage_mv(in_voltage_mv),
    .bp           (bp_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  bci_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  bci_back #(
    .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_pop_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_fraction(out_charge_fraction)
  );

endmodule

// ----- sim/battery_charge_interpolator_tb.sv -----
`timescale 1ns / 100ps

module battery_charge_interpolator_tb;

  typedef logic [bci_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [bci_pkg::FRAC_W-1:0]    frac_t;

  localparam int N_BP         = 8;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 30;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 90;

  localparam cfg_idx_t REG_BP0       = cfg_idx_t'(0);
  // indexes above the table: the block must drop these writes
  localparam cfg_idx_t REG_SPARE_LO  = cfg_idx_t'(bci_pkg::BP_REGS);

  localparam frac_t CHARGE_EMPTY = '0;

  typedef enum int { IDLE_SENDER_HEAVY, IDLE_RECEIVER_HEAVY, IDLE_NONE } idle_mode_t;

  logic          clk                 = 1'b0;
  logic          rst_n               = 1'b0;
  logic          in_valid            = 1'b0;
  logic          in_stall;
  bci_pkg::mv_t  in_voltage_mv       = '0;
  logic          out_valid;
  logic          out_stall           = 1'b0;
  frac_t         out_charge_fraction;
  logic          cfg_wr_en           = 1'b0;
  cfg_idx_t      cfg_index           = '0;
  bci_pkg::mv_t  cfg_data            = '0;

  bci_pkg::bp_tbl_t bp_tbl = bci_pkg::BP_RESET;
  bci_pkg::mv_t     voltage_q[$];
  frac_t            charge_q[$];
  idle_mode_t       idle_mode = IDLE_SENDER_HEAVY;
  int               accepted_cnt = 0;
  int               error_cnt = 0;
  int               cycle_cnt = 0;
  int               hold_left = 0;
  logic             hold_armed = 1'b1;

  battery_charge_interpolator #(.NUM_BREAKPOINTS(N_BP)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_voltage_mv       (in_voltage_mv),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_charge_fraction (out_charge_fraction),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // first breakpoint strictly above v closes the segment; earlier ones are all <= v
  function automatic frac_t expected_charge(input bci_pkg::mv_t v);
    longint unsigned lo, hi, width, num, den;
    if (v < bp_tbl[0]) return CHARGE_EMPTY;
    for (int seg = 1; seg < N_BP; seg++) begin
      if (v < bp_tbl[seg]) begin
        lo    = bp_tbl[seg-1];
        hi    = bp_tbl[seg];
        width = hi - lo;
        num   = 64'd65536 * (longint'(seg - 1) * width + (longint'(v) - lo));
        den   = longint'(N_BP - 1) * width;
        return frac_t'(num / den);
      end
    end
    return bci_pkg::FULL_SCALE;
  endfunction

  // bias towards breakpoint edges, where segment selection flips
  function automatic bci_pkg::mv_t pick_voltage();
    int unsigned k;
    if ($urandom_range(0, 99) < 40) begin
      k = $urandom_range(0, N_BP - 1);
      return bp_tbl[k] + bci_pkg::mv_t'($urandom_range(0, 2)) - bci_pkg::mv_t'(1);
    end
    return bci_pkg::mv_t'($urandom);
  endfunction

  function automatic int sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER_HEAVY:   return 27;
      IDLE_RECEIVER_HEAVY: return 72;
      default:             return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (idle_mode)
      IDLE_SENDER_HEAVY:   return 72;
      IDLE_RECEIVER_HEAVY: return 27;
      default:             return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        charge_q.push_back(expected_charge(in_voltage_mv));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (voltage_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid      <= 1'b1;
          in_voltage_mv <= voltage_q.pop_front();
        end else begin
          in_valid      <= 1'b0;
          in_voltage_mv <= bci_pkg::mv_t'($urandom);
        end
      end
    end
  end

  // one long receiver hold mid-run so the front end backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_cnt >= 300 && voltage_q.size() >= 20) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    frac_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (charge_q.size() == 0) begin
          $display("%0t: unexpected transaction, charge_fraction expected none got %0d",
                   $time, out_charge_fraction);
          error_cnt++;
        end else begin
          want = charge_q.pop_front();
          if (out_charge_fraction !== want) begin
            $display("%0t: charge_fraction expected %0d got %0d",
                     $time, want, out_charge_fraction);
            error_cnt++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("battery_charge_interpolator: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input bci_pkg::mv_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < bci_pkg::BP_REGS) bp_tbl[idx[bci_pkg::IDX_W-1:0]] = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_table(input bci_pkg::bp_tbl_t tbl);
    for (int k = 0; k < bci_pkg::BP_REGS; k++)
      write_reg(REG_BP0 + cfg_idx_t'(k), tbl[k]);
    write_reg(REG_SPARE_LO + cfg_idx_t'($urandom_range(0, 7)), bci_pkg::mv_t'($urandom));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (voltage_q.size() != 0 || in_valid || charge_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    for (int m = 0; m < 3; m++) begin
      idle_mode = idle_mode_t'(m);
      repeat (count / 3) voltage_q.push_back(pick_voltage());
      while (voltage_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    bci_pkg::bp_tbl_t tbl;
    int unsigned      base;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table: field extremes, both ends and segment edges
    voltage_q.push_back(16'd0);
    voltage_q.push_back(16'd65535);
    voltage_q.push_back(16'd29999);
    voltage_q.push_back(16'd30000);
    voltage_q.push_back(16'd30001);
    voltage_q.push_back(16'd31999);
    voltage_q.push_back(16'd32000);
    voltage_q.push_back(16'd36000);
    voltage_q.push_back(16'd38499);
    voltage_q.push_back(16'd40000);
    voltage_q.push_back(16'd41999);
    voltage_q.push_back(16'd42000);
    voltage_q.push_back(16'd42001);
    voltage_q.push_back(16'h5555);
    voltage_q.push_back(16'hAAAA);
    run_random(PHASE_ITEMS);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: tbl = {16'd65535, 16'd56000, 16'd47000, 16'd38000,
                  16'd28000, 16'd19000, 16'd9000,  16'd0};
        // descending steps and repeated breakpoints
        1: tbl = {16'd65535, 16'd65535, 16'd2000, 16'd3000,
                  16'd3000,  16'd500,   16'd1000, 16'd1000};
        2: tbl = {bci_pkg::BP_REGS{16'hFFFF}};
        3: tbl = {bci_pkg::BP_REGS{16'h0000}};
        4: begin
          // tight segments: large quotient per millivolt
          base = $urandom_range(0, 65535 - 64);
          for (int k = 0; k < bci_pkg::BP_REGS; k++) begin
            tbl[k] = bci_pkg::mv_t'(base);
            base += $urandom_range(1, 8);
          end
        end
        default: begin
          for (int k = 0; k < bci_pkg::BP_REGS; k++) tbl[k] = bci_pkg::mv_t'($urandom);
        end
      endcase
      wait_idle();
      load_table(tbl);
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    if (error_cnt == 0) begin
      $display("battery_charge_interpolator: match");
    end else begin
      $display("battery_charge_interpolator: mismatch");
    end
    $finish;
  end

endmodule
